### sv/fpg_pkg.sv
// ----------------------------------------------------------------------------
// fpg_pkg
// Shared types and constants of the falling particle grid block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpg_pkg;

    // Cell word: valid flag on top of packed RGBA (red in the high byte)
    localparam int CELL_W     = 33;
    localparam int CELL_VALID = 32;
    localparam int RGBA_W     = 32;

    // Direction LFSR: Galois, shift right, taps x^16+x^14+x^13+x^11+1
    localparam int          LFSR_W     = 16;
    localparam logic [15:0] LFSR_MASK  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'h0001;

    // Register port
    localparam int         APB_AW          = 3;
    localparam int         APB_DW          = 32;
    localparam logic [0:0] REG_RANDOM_SEED = 1'b0;

    // Stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] rgba;
    } t_cmd;

    typedef struct packed {
        logic        in_range;
        logic        occupied;
        logic [31:0] rgba;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INSERT,
        ST_READ_ISSUE,
        ST_READ_DATA,
        ST_RD_HERE,
        ST_CHK_HERE,
        ST_CHK_BELOW,
        ST_CHK_FIRST,
        ST_CHK_SECOND,
        ST_CLR_HERE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

### sv/falling_particle_grid_step.sv
// ----------------------------------------------------------------------------
// falling_particle_grid_step
// Falling-sand grid with insert, tick and read commands over a stream port.
// ----------------------------------------------------------------------------
// After reset the block clears every cell, one per cycle, and takes no
// word until done; register writes are taken during that time. Then it
// handles one word at a time: an insert writes the cell, a read issues the
// address and then takes the data, and an out-of-range or unused command
// goes straight to finish. A tick sweeps (GRID_HEIGHT-1)*GRID_WIDTH cells;
// each is read, and a particle then checks the cell below and, if that is
// full, the diagonals; where it moves, the cell it left is cleared. The
// cell RAM has a single port, which does one read or one write per cycle.
// A result waits in an output register while the next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module falling_particle_grid_step #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // {alpha, blue, green, red, row, col, op} from bit 0: op[1:0], col[9:2],
    // row[17:10], in_red[25:18], in_green[33:26], in_blue[41:34],
    // in_alpha[49:42], zero fill above
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [fpg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // from bit 0: in_range[0], occupied[1], out_red[9:2], out_green[17:10],
    // out_blue[25:18], out_alpha[33:26], zero fill above
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [fpg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fpg_pkg::APB_AW-1:0]    paddr,
    input  wire logic [fpg_pkg::APB_DW-1:0]    pwdata,
    output logic      [fpg_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int NCELL = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(NCELL);

    logic                       w_cfg_wr;
    logic                       w_seed_sel;
    logic [fpg_pkg::LFSR_W-1:0] w_seed_in;
    logic [fpg_pkg::LFSR_W-1:0] r_random_seed;

    fpg_pkg::t_cmd              w_cmd;
    fpg_pkg::t_result           w_res;
    logic                       w_done;
    logic                       w_out_free;
    logic                       w_dir_bit;
    logic                       w_dir_step;
    logic                       w_mem_we;
    logic [AW-1:0]              w_mem_addr;
    logic [fpg_pkg::CELL_W-1:0] w_mem_wdata;
    logic [fpg_pkg::CELL_W-1:0] w_mem_rdata;

    logic                       r_m_valid;
    fpg_pkg::t_result           r_m_res;

    // Register port: zero seed is stored as one
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_seed_sel = (paddr[fpg_pkg::APB_AW-1:2] == fpg_pkg::REG_RANDOM_SEED);
    assign w_seed_in  = (pwdata[fpg_pkg::LFSR_W-1:0] == '0) ? fpg_pkg::SEED_RESET
                                                           : pwdata[fpg_pkg::LFSR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_random_seed <= fpg_pkg::SEED_RESET;
        end else if (w_cfg_wr && w_seed_sel) begin
            r_random_seed <= w_seed_in;
        end
    end

    assign prdata = w_seed_sel ? {{(fpg_pkg::APB_DW - fpg_pkg::LFSR_W){1'b0}}, r_random_seed}
                               : '0;

    // Unpack the input word
    assign w_cmd.op   = fpg_pkg::t_op'(s_axis_tdata[1:0]);
    assign w_cmd.col  = s_axis_tdata[9:2];
    assign w_cmd.row  = s_axis_tdata[17:10];
    assign w_cmd.rgba = {s_axis_tdata[25:18], s_axis_tdata[33:26],
                         s_axis_tdata[41:34], s_axis_tdata[49:42]};

    fpg_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_cfg_wr && w_seed_sel),
        .i_seed  (w_seed_in),
        .i_step  (w_dir_step),
        .o_bit   (w_dir_bit)
    );

    fpg_cell_ram #(
        .DEPTH (NCELL),
        .AW    (AW)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    fpg_ctrl #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (w_cmd),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_res       (w_res),
        .i_dir_bit   (w_dir_bit),
        .o_dir_step  (w_dir_step),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    // Output register: load on completion, drop when taken
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_res.rgba[7:0], r_m_res.rgba[15:8],
                            r_m_res.rgba[23:16], r_m_res.rgba[31:24],
                            r_m_res.occupied, r_m_res.in_range};

endmodule

`default_nettype wire

### sv/fpg_cell_ram.sv
// ----------------------------------------------------------------------------
// fpg_cell_ram
// Single-port cell memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpg_cell_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_addr,
    input  wire logic [fpg_pkg::CELL_W-1:0] i_wdata,
    output logic      [fpg_pkg::CELL_W-1:0] o_rdata
);

    logic [fpg_pkg::CELL_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### sv/fpg_lfsr.sv
// ----------------------------------------------------------------------------
// fpg_lfsr
// 16-bit Galois LFSR that hands out one direction bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module fpg_lfsr (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic [fpg_pkg::LFSR_W-1:0] i_seed,
    input  wire logic                       i_step,
    output logic                            o_bit
);

    logic [fpg_pkg::LFSR_W-1:0] r_lfsr;

    // Load takes priority, else shift right and fold in taps on a one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= fpg_pkg::SEED_RESET;
        end else if (i_load) begin
            r_lfsr <= i_seed;
        end else if (i_step) begin
            r_lfsr <= (r_lfsr >> 1) ^ (r_lfsr[0] ? fpg_pkg::LFSR_MASK : '0);
        end
    end

    assign o_bit = r_lfsr[0];

endmodule

`default_nettype wire

### sv/fpg_ctrl.sv
// ----------------------------------------------------------------------------
// fpg_ctrl
// Sequencer that clears the grid, runs inserts and reads, and sweeps a tick
// cell by cell through the shared address adder and the single RAM port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpg_ctrl #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int AW          = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_ready,
    input  wire fpg_pkg::t_cmd              i_cmd,
    input  wire logic                       i_out_free,
    output logic                            o_done,
    output fpg_pkg::t_result                o_res,
    input  wire logic                       i_dir_bit,
    output logic                            o_dir_step,
    output logic                            o_mem_we,
    output logic      [AW-1:0]              o_mem_addr,
    output logic      [fpg_pkg::CELL_W-1:0] o_mem_wdata,
    input  wire logic [fpg_pkg::CELL_W-1:0] i_mem_rdata
);

    localparam int NCELL = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW    = $clog2(GRID_WIDTH);
    localparam int RW    = $clog2(GRID_HEIGHT);

    fpg_pkg::t_state r_state, n_state;

    logic [AW-1:0]              r_here;
    logic [AW-1:0]              r_addr;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;
    logic                       r_dir;
    logic [fpg_pkg::RGBA_W-1:0] r_rgba;
    logic [fpg_pkg::RGBA_W-1:0] r_part;
    fpg_pkg::t_result           r_res;

    logic                  w_inside;
    logic                  w_rd_valid;
    logic [AW-1:0]         w_below, w_left, w_right, w_first, w_second;
    logic                  w_first_ok, w_second_ok;
    logic                  w_col_last, w_last_cell, w_adv;
    fpg_pkg::t_state       w_adv_state;

    assign w_inside = (int'(i_cmd.col) < GRID_WIDTH) && (int'(i_cmd.row) < GRID_HEIGHT);
    assign w_rd_valid = i_mem_rdata[fpg_pkg::CELL_VALID];

    // Neighbor addresses from the shared adder
    assign w_below = r_here + AW'(GRID_WIDTH);
    assign w_left  = w_below - AW'(1);
    assign w_right = w_below + AW'(1);

    assign w_col_last  = (r_col == CW'(GRID_WIDTH - 1));
    assign w_last_cell = w_col_last && (r_row == '0);

    // Random bit picks which diagonal goes first; off-grid counts as full
    assign w_first     = r_dir ? w_left  : w_right;
    assign w_second    = r_dir ? w_right : w_left;
    assign w_first_ok  = r_dir ? (r_col != '0) : !w_col_last;
    assign w_second_ok = r_dir ? !w_col_last : (r_col != '0);

    assign w_adv_state = w_last_cell ? fpg_pkg::ST_FINISH : fpg_pkg::ST_RD_HERE;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpg_pkg::ST_CLEAR: begin
                if (r_here == AW'(NCELL - 1)) begin
                    n_state = fpg_pkg::ST_IDLE;
                end
            end
            fpg_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        fpg_pkg::OP_INSERT:
                            n_state = w_inside ? fpg_pkg::ST_INSERT : fpg_pkg::ST_FINISH;
                        fpg_pkg::OP_READ:
                            n_state = w_inside ? fpg_pkg::ST_READ_ISSUE : fpg_pkg::ST_FINISH;
                        fpg_pkg::OP_TICK:
                            n_state = fpg_pkg::ST_RD_HERE;
                        default:
                            n_state = fpg_pkg::ST_FINISH;
                    endcase
                end
            end
            fpg_pkg::ST_INSERT:     n_state = fpg_pkg::ST_FINISH;
            fpg_pkg::ST_READ_ISSUE: n_state = fpg_pkg::ST_READ_DATA;
            fpg_pkg::ST_READ_DATA:  n_state = fpg_pkg::ST_FINISH;
            fpg_pkg::ST_RD_HERE:    n_state = fpg_pkg::ST_CHK_HERE;
            fpg_pkg::ST_CHK_HERE: begin
                n_state = w_rd_valid ? fpg_pkg::ST_CHK_BELOW : w_adv_state;
            end
            fpg_pkg::ST_CHK_BELOW: begin
                if (!w_rd_valid) begin
                    n_state = fpg_pkg::ST_CLR_HERE;
                end else if (w_first_ok) begin
                    n_state = fpg_pkg::ST_CHK_FIRST;
                end else if (w_second_ok) begin
                    n_state = fpg_pkg::ST_CHK_SECOND;
                end else begin
                    n_state = w_adv_state;
                end
            end
            fpg_pkg::ST_CHK_FIRST: begin
                if (!w_rd_valid) begin
                    n_state = fpg_pkg::ST_CLR_HERE;
                end else if (w_second_ok) begin
                    n_state = fpg_pkg::ST_CHK_SECOND;
                end else begin
                    n_state = w_adv_state;
                end
            end
            fpg_pkg::ST_CHK_SECOND: begin
                n_state = !w_rd_valid ? fpg_pkg::ST_CLR_HERE : w_adv_state;
            end
            fpg_pkg::ST_CLR_HERE:   n_state = w_adv_state;
            fpg_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    n_state = fpg_pkg::ST_IDLE;
                end
            end
            default:                n_state = fpg_pkg::ST_CLEAR;
        endcase
    end

    // Memory port, LFSR step, sweep advance and completion
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_addr  = r_here;
        o_mem_wdata = '0;
        o_dir_step  = 1'b0;
        o_done      = 1'b0;
        w_adv       = 1'b0;
        unique case (r_state)
            fpg_pkg::ST_CLEAR: begin
                o_mem_we = 1'b1;
            end
            fpg_pkg::ST_IDLE: begin
            end
            fpg_pkg::ST_INSERT: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_addr;
                o_mem_wdata = {1'b1, r_rgba};
            end
            fpg_pkg::ST_READ_ISSUE: begin
                o_mem_addr = r_addr;
            end
            fpg_pkg::ST_READ_DATA: begin
            end
            fpg_pkg::ST_RD_HERE: begin
                o_dir_step = 1'b1;
            end
            fpg_pkg::ST_CHK_HERE: begin
                if (w_rd_valid) begin
                    o_mem_addr = w_below;
                end else begin
                    w_adv = 1'b1;
                end
            end
            fpg_pkg::ST_CHK_BELOW: begin
                if (!w_rd_valid) begin
                    o_mem_we    = 1'b1;
                    o_mem_addr  = w_below;
                    o_mem_wdata = {1'b1, r_part};
                end else if (w_first_ok) begin
                    o_mem_addr = w_first;
                end else if (w_second_ok) begin
                    o_mem_addr = w_second;
                end else begin
                    w_adv = 1'b1;
                end
            end
            fpg_pkg::ST_CHK_FIRST: begin
                if (!w_rd_valid) begin
                    o_mem_we    = 1'b1;
                    o_mem_addr  = w_first;
                    o_mem_wdata = {1'b1, r_part};
                end else if (w_second_ok) begin
                    o_mem_addr = w_second;
                end else begin
                    w_adv = 1'b1;
                end
            end
            fpg_pkg::ST_CHK_SECOND: begin
                if (!w_rd_valid) begin
                    o_mem_we    = 1'b1;
                    o_mem_addr  = w_second;
                    o_mem_wdata = {1'b1, r_part};
                end else begin
                    w_adv = 1'b1;
                end
            end
            fpg_pkg::ST_CLR_HERE: begin
                o_mem_we = 1'b1;
                w_adv    = 1'b1;
            end
            fpg_pkg::ST_FINISH: begin
                o_done = i_out_free;
            end
            default: begin
            end
        endcase
    end

    // State and sweep counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpg_pkg::ST_CLEAR;
            r_here  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fpg_pkg::ST_CLEAR) begin
                r_here <= r_here + AW'(1);
            end else if (r_state == fpg_pkg::ST_IDLE && i_cmd_valid &&
                         i_cmd.op == fpg_pkg::OP_TICK) begin
                r_row  <= RW'(GRID_HEIGHT - 2);
                r_col  <= '0;
                r_here <= AW'((GRID_HEIGHT - 2) * GRID_WIDTH);
            end else if (w_adv) begin
                if (w_col_last) begin
                    r_col  <= '0;
                    r_row  <= r_row - RW'(1);
                    r_here <= r_here - AW'(2 * GRID_WIDTH - 1);
                end else begin
                    r_col  <= r_col + CW'(1);
                    r_here <= r_here + AW'(1);
                end
            end
        end
    end

    // Command latch, carried particle and result
    always_ff @(posedge i_clk) begin
        if (r_state == fpg_pkg::ST_IDLE && i_cmd_valid) begin
            r_addr         <= AW'(int'(i_cmd.row) * GRID_WIDTH + int'(i_cmd.col));
            r_rgba         <= i_cmd.rgba;
            r_res.in_range <= (i_cmd.op == fpg_pkg::OP_TICK) ||
                              (((i_cmd.op == fpg_pkg::OP_INSERT) ||
                                (i_cmd.op == fpg_pkg::OP_READ)) && w_inside);
            r_res.occupied <= 1'b0;
            r_res.rgba     <= '0;
        end
        if (r_state == fpg_pkg::ST_RD_HERE) begin
            r_dir <= i_dir_bit;
        end
        if (r_state == fpg_pkg::ST_CHK_HERE) begin
            r_part <= i_mem_rdata[fpg_pkg::RGBA_W-1:0];
        end
        if (r_state == fpg_pkg::ST_READ_DATA) begin
            r_res.occupied <= w_rd_valid;
            r_res.rgba     <= w_rd_valid ? i_mem_rdata[fpg_pkg::RGBA_W-1:0] : '0;
        end
    end

    assign o_cmd_ready = (r_state == fpg_pkg::ST_IDLE);
    assign o_res       = r_res;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpg_pkg::ST_IDLE) |-> !o_mem_we)
        else $error("cell write while idle");

    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (int'(o_mem_addr) < NCELL))
        else $error("cell write outside grid");

    a_occ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.in_range || !o_res.occupied))
        else $error("occupied result outside grid");

endmodule

`default_nettype wire
